// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge while reset is released
`define VSW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check prop at every clock edge, reset included
`define VSW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hdl/vsw_pkg.sv
package vsw_pkg;

    localparam int DIV_W     = 31;
    localparam int IDX_OUT_W = 10;
    localparam int CNT_OUT_W = 11;
    localparam int NUM_AXES  = 3;

    localparam logic [DIV_W-1:0] MD_RESET = 31'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_SCAN,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_cell_ctl;

endpackage

// File: hdl/vsw_ram.sv
module vsw_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/vsw_div_cell.sv
module vsw_div_cell #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [vsw_pkg::DIV_W-1:0] i_divisor,
    input  vsw_pkg::t_cell_ctl       i_ctl,
    input  logic [vsw_pkg::DIV_W-1:0] i_rem,
    input  logic [COORD_WIDTH-1:0]   i_mq,
    output vsw_pkg::t_cell_ctl       o_ctl,
    output logic [vsw_pkg::DIV_W-1:0] o_rem,
    output logic [COORD_WIDTH-1:0]   o_mq
);

    vsw_pkg::t_cell_ctl        r_ctl;
    logic [vsw_pkg::DIV_W-1:0] r_rem;
    logic [COORD_WIDTH-1:0]    r_mq;

    logic [vsw_pkg::DIV_W:0]   trial;
    logic [vsw_pkg::DIV_W:0]   diff;
    logic                      ge;
    logic [vsw_pkg::DIV_W-1:0] n_rem;
    logic [COORD_WIDTH-1:0]    n_mq;

    always_comb begin
        trial = {i_rem, i_mq[COORD_WIDTH-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
        n_rem = ge ? diff[vsw_pkg::DIV_W-1:0] : trial[vsw_pkg::DIV_W-1:0];
        n_mq  = {i_mq[COORD_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_mq  <= n_mq;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_mq  = r_mq;

endmodule

// File: hdl/vsw_div_chain.sv
module vsw_div_chain #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [vsw_pkg::DIV_W-1:0] i_divisor,
    input  logic                     i_valid,
    input  logic [COORD_WIDTH-1:0]   i_value,
    output logic                     o_valid,
    output logic [COORD_WIDTH-1:0]   o_key
);

    vsw_pkg::t_cell_ctl        ctl [COORD_WIDTH+1];
    logic [vsw_pkg::DIV_W-1:0] rem [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0]    mq  [COORD_WIDTH+1];

    logic                      neg_in;
    logic [COORD_WIDTH-1:0]    quo;

    assign neg_in     = i_value[COORD_WIDTH-1];
    assign ctl[0]     = '{valid: i_valid, neg: neg_in};
    assign rem[0]     = '0;
    assign mq[0]      = neg_in ? (~i_value + COORD_WIDTH'(1)) : i_value;

    for (genvar g = 0; g < COORD_WIDTH; g++) begin : g_cell
        vsw_div_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (i_divisor),
            .i_ctl     (ctl[g]),
            .i_rem     (rem[g]),
            .i_mq      (mq[g]),
            .o_ctl     (ctl[g+1]),
            .o_rem     (rem[g+1]),
            .o_mq      (mq[g+1])
        );
    end

    assign quo     = mq[COORD_WIDTH];
    assign o_valid = ctl[COORD_WIDTH].valid;
    assign o_key   = ctl[COORD_WIDTH].neg ? (~quo + COORD_WIDTH'(1)) : quo;

endmodule

// File: hdl/vertex_snap_weld.sv
// Lookup: the stored entries are scanned in order until a match (match at entry k: k + 1
//   entries scanned; miss: the stored count).
// Throughput: one item in flight; each item passes the divider cell chain (one quotient bit per
//   cell) and the key table scan, which reads one entry per cycle.
// Reset: synchronous, active low; clears control, stored count, output valid and sets
//   merge distance to 65536. Key table contents are not cleared.
module vertex_snap_weld #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vsw_pkg::DIV_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_WIDTH-1:0]        i_coord_x,
    input  logic [COORD_WIDTH-1:0]        i_coord_y,
    input  logic [COORD_WIDTH-1:0]        i_coord_z,
    input  logic                          i_last_in_object,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vsw_pkg::IDX_OUT_W-1:0] o_vertex_index,
    output logic                          o_is_new,
    output logic                          o_table_full,
    output logic [vsw_pkg::CNT_OUT_W-1:0] o_unique_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = vsw_pkg::NUM_AXES * COORD_WIDTH;

    vsw_pkg::t_state           r_state, n_state;
    logic [vsw_pkg::DIV_W-1:0] r_md, n_md;
    logic [1:0]                r_feed_cnt, n_feed_cnt;
    logic [1:0]                r_col_cnt, n_col_cnt;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_issue, n_issue;
    logic                      r_pend, n_pend;
    logic [IDX_W-1:0]          r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]          r_res_idx, n_res_idx;
    logic                      r_res_new, n_res_new;
    logic                      r_res_full, n_res_full;
    logic                      r_out_valid, n_out_valid;

    logic [COORD_WIDTH-1:0]    r_cx, r_cy, r_cz;
    logic                      r_last;
    logic [COORD_WIDTH-1:0]    r_kx, r_ky, r_kz;
    logic [IDX_W-1:0]          r_out_idx;
    logic                      r_out_new;
    logic                      r_out_full;
    logic [CNT_W-1:0]          r_out_cnt;

    logic                      in_accept;
    logic                      out_free;
    logic                      push_fire;
    logic [CNT_W-1:0]          cnt_after;
    logic [vsw_pkg::DIV_W-1:0] divisor;
    logic                      chain_in_valid;
    logic [COORD_WIDTH-1:0]    chain_in_value;
    logic                      chain_out_valid;
    logic [COORD_WIDTH-1:0]    chain_key;
    logic                      rd_en;
    logic [KEY_W-1:0]          rd_data;
    logic [KEY_W-1:0]          key_word;
    logic                      hit;

    assign divisor  = (r_md == '0) ? vsw_pkg::DIV_W'(1) : r_md;
    assign key_word = {r_kx, r_ky, r_kz};
    assign hit      = r_pend && (rd_data == key_word);
    assign out_free = !r_out_valid || !i_stall;
    assign cnt_after = r_count + CNT_W'(r_res_new);

    always_comb begin
        unique case (r_feed_cnt)
            2'd0:    chain_in_value = r_cx;
            2'd1:    chain_in_value = r_cy;
            default: chain_in_value = r_cz;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_md        = r_md;
        n_feed_cnt  = r_feed_cnt;
        n_col_cnt   = r_col_cnt;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_res_idx   = r_res_idx;
        n_res_new   = r_res_new;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid && i_stall;
        in_accept      = 1'b0;
        push_fire      = 1'b0;
        chain_in_valid = 1'b0;
        rd_en          = 1'b0;

        if (i_cfg_wr_en) begin
            n_md = i_cfg_wr_data;
        end

        unique case (r_state)
            vsw_pkg::S_IDLE: begin
                if (i_valid) begin
                    in_accept  = 1'b1;
                    n_feed_cnt = '0;
                    n_state    = vsw_pkg::S_FEED;
                end
            end
            vsw_pkg::S_FEED: begin
                chain_in_valid = 1'b1;
                n_feed_cnt     = r_feed_cnt + 2'd1;
                if (r_feed_cnt == 2'd2) begin
                    n_col_cnt = '0;
                    n_state   = vsw_pkg::S_WAIT;
                end
            end
            vsw_pkg::S_WAIT: begin
                if (chain_out_valid) begin
                    n_col_cnt = r_col_cnt + 2'd1;
                    if (r_col_cnt == 2'd2) begin
                        n_issue = '0;
                        n_pend  = 1'b0;
                        n_state = vsw_pkg::S_SCAN;
                    end
                end
            end
            vsw_pkg::S_SCAN: begin
                rd_en      = (r_issue < r_count);
                n_pend     = rd_en;
                n_pend_idx = r_issue[IDX_W-1:0];
                if (rd_en) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                priority if (hit) begin
                    n_res_idx  = r_pend_idx;
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_state    = vsw_pkg::S_PUSH;
                end else if (r_issue == r_count) begin
                    if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_res_idx  = IDX_W'(TABLE_DEPTH - 1);
                        n_res_new  = 1'b0;
                        n_res_full = 1'b1;
                    end else begin
                        n_res_idx  = r_count[IDX_W-1:0];
                        n_res_new  = 1'b1;
                        n_res_full = 1'b0;
                    end
                    n_state = vsw_pkg::S_PUSH;
                end else begin
                    n_state = vsw_pkg::S_SCAN;
                end
            end
            vsw_pkg::S_PUSH: begin
                if (out_free) begin
                    push_fire   = 1'b1;
                    n_out_valid = 1'b1;
                    n_count     = r_last ? '0 : cnt_after;
                    n_state     = vsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vsw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsw_pkg::S_IDLE;
            r_md        <= vsw_pkg::MD_RESET;
            r_feed_cnt  <= '0;
            r_col_cnt   <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_md        <= n_md;
            r_feed_cnt  <= n_feed_cnt;
            r_col_cnt   <= n_col_cnt;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_res_idx  <= n_res_idx;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        if (in_accept) begin
            r_cx   <= i_coord_x;
            r_cy   <= i_coord_y;
            r_cz   <= i_coord_z;
            r_last <= i_last_in_object;
        end
        if (chain_out_valid) begin
            r_kx <= r_ky;
            r_ky <= r_kz;
            r_kz <= chain_key;
        end
        if (push_fire) begin
            r_out_idx  <= r_res_idx;
            r_out_new  <= r_res_new;
            r_out_full <= r_res_full;
            r_out_cnt  <= cnt_after;
        end
    end

    vsw_div_chain #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (divisor),
        .i_valid   (chain_in_valid),
        .i_value   (chain_in_value),
        .o_valid   (chain_out_valid),
        .o_key     (chain_key)
    );

    vsw_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push_fire && r_res_new),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (key_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_stall        = (r_state != vsw_pkg::S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_vertex_index = vsw_pkg::IDX_OUT_W'(r_out_idx);
    assign o_is_new       = r_out_new;
    assign o_table_full   = r_out_full;
    assign o_unique_count = vsw_pkg::CNT_OUT_W'(r_out_cnt);

endmodule

// File: hdl/vsw_checker.sv
`include "assert_macros.svh"

module vsw_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [vsw_pkg::IDX_OUT_W-1:0] o_vertex_index,
    input logic                          o_is_new,
    input logic                          o_table_full,
    input logic [vsw_pkg::CNT_OUT_W-1:0] o_unique_count
);

    `VSW_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid,
        "output valid after reset")

    `VSW_ASSERT(a_accept_then_busy, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall,
        "second input transaction taken while an item is in flight")

    `VSW_ASSERT(a_new_full_exclusive, i_clk, i_rst_n,
        o_valid |-> !(o_is_new && o_table_full),
        "result flagged both new and full")

    `VSW_ASSERT(a_full_saturates, i_clk, i_rst_n,
        (o_valid && o_table_full) |->
            ((o_vertex_index == vsw_pkg::IDX_OUT_W'(TABLE_DEPTH - 1))
            && (o_unique_count == vsw_pkg::CNT_OUT_W'(TABLE_DEPTH))),
        "full result without saturated index and count")

    `VSW_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_vertex_index) && $stable(o_is_new)
            && $stable(o_table_full) && $stable(o_unique_count)),
        "stalled result transaction changed")

endmodule

bind vertex_snap_weld vsw_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_vsw_checker (.*);

// File: tb/vertex_snap_weld_tb.sv
module vertex_snap_weld_tb;

    localparam int TABLE_DEPTH  = 1024;
    localparam int COORD_WIDTH  = 32;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 19;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 1100;
    localparam longint RUN_LIMIT = 64_000_000;

    typedef struct {
        logic [vsw_pkg::IDX_OUT_W-1:0] vertex_index;
        logic                          is_new;
        logic                          table_full;
        logic [vsw_pkg::CNT_OUT_W-1:0] unique_count;
    } t_weld_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [vsw_pkg::DIV_W-1:0]     i_cfg_wr_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [COORD_WIDTH-1:0]        i_coord_x;
    logic [COORD_WIDTH-1:0]        i_coord_y;
    logic [COORD_WIDTH-1:0]        i_coord_z;
    logic                          i_last_in_object;
    logic                          o_valid;
    logic                          i_stall;
    logic [vsw_pkg::IDX_OUT_W-1:0] o_vertex_index;
    logic                          o_is_new;
    logic                          o_table_full;
    logic [vsw_pkg::CNT_OUT_W-1:0] o_unique_count;

    // weld table mirror
    logic [vsw_pkg::DIV_W-1:0] cell_size;
    logic [31:0]               grid_x [TABLE_DEPTH];
    logic [31:0]               grid_y [TABLE_DEPTH];
    logic [31:0]               grid_z [TABLE_DEPTH];
    int unsigned               live_keys;
    t_weld_result              pending_welds [$];

    bit idling;
    int stall_budget;
    int errors;
    int vertices_sent;
    int results_seen;
    int new_keys;
    int welded;
    int full_hits;
    int objects;
    int cfg_writes;

    vertex_snap_weld dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_last_in_object (i_last_in_object),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_vertex_index   (o_vertex_index),
        .o_is_new         (o_is_new),
        .o_table_full     (o_table_full),
        .o_unique_count   (o_unique_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, pending_welds.size());
        $display("** vertex_snap_weld: FAILED **");
        $finish;
    end

    function automatic logic [31:0] snap_to_grid(input logic [31:0] coord);
        longint unsigned mag;
        longint unsigned step;
        longint unsigned quot;
        step = (cell_size == '0) ? 64'd1 : 64'(cell_size);
        mag  = coord[31] ? (64'h1_0000_0000 - 64'(coord)) : 64'(coord);
        quot = mag / step;
        return coord[31] ? 32'(-quot) : 32'(quot);
    endfunction

    function automatic t_weld_result weld_vertex(input logic [31:0] x, input logic [31:0] y,
                                                 input logic [31:0] z, input logic last);
        t_weld_result r;
        logic [31:0]  kx;
        logic [31:0]  ky;
        logic [31:0]  kz;
        int           hit;
        int           k;
        kx  = snap_to_grid(x);
        ky  = snap_to_grid(y);
        kz  = snap_to_grid(z);
        hit = -1;
        for (k = 0; k < live_keys; k++) begin
            if (hit < 0 && grid_x[k] == kx && grid_y[k] == ky && grid_z[k] == kz)
                hit = k;
        end
        r.is_new     = 1'b0;
        r.table_full = 1'b0;
        if (hit >= 0) begin
            r.vertex_index = vsw_pkg::IDX_OUT_W'(hit);
        end else if (live_keys < TABLE_DEPTH) begin
            grid_x[live_keys] = kx;
            grid_y[live_keys] = ky;
            grid_z[live_keys] = kz;
            r.vertex_index    = vsw_pkg::IDX_OUT_W'(live_keys);
            r.is_new          = 1'b1;
            live_keys++;
        end else begin
            r.vertex_index = vsw_pkg::IDX_OUT_W'(TABLE_DEPTH - 1);
            r.table_full   = 1'b1;
        end
        r.unique_count = vsw_pkg::CNT_OUT_W'(live_keys);
        if (last)
            live_keys = 0;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // result side: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_weld_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_welds.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d",
                         $time, o_vertex_index);
                errors++;
            end else begin
                want = pending_welds.pop_front();
                results_seen++;
                check_field("vertex_index", want.vertex_index, o_vertex_index);
                check_field("is_new", want.is_new, o_is_new);
                check_field("table_full", want.table_full, o_table_full);
                check_field("unique_count", want.unique_count, o_unique_count);
            end
            stall_budget = idling ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    // hold stall while budget remains; spend it only on cycles with a result waiting
    always @(negedge i_clk) begin
        i_stall <= (stall_budget > 0);
        if (o_valid === 1'b1 && stall_budget > 0)
            stall_budget = stall_budget - 1;
    end

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        t_weld_result r;
        int           gap;
        gap = idling ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_coord_x        <= x;
        i_coord_y        <= y;
        i_coord_z        <= z;
        i_last_in_object <= last;
        do @(posedge i_clk); while (o_stall);
        r = weld_vertex(x, y, z, last);
        pending_welds.push_back(r);
        vertices_sent++;
        new_keys  += r.is_new;
        full_hits += r.table_full;
        welded    += !r.is_new && !r.table_full;
        objects   += last;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_welds.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_cell_size(input logic [vsw_pkg::DIV_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cell_size = value;
        cfg_writes++;
    endtask

    task automatic test_default_cell();
        idling = 1'b1;
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_vertex(32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_0001, 1'b0);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_vertex(32'h0001_0005, 32'hFFFE_FFFB, 32'h0000_0064, 1'b1);
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_cell_extremes();
        set_cell_size(31'd1);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        set_cell_size(31'h7FFF_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0000, 1'b0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        // zero cell size snaps like a cell of one
        set_cell_size(31'd0);
        send_vertex(32'h0000_0005, 32'hFFFF_FFFB, 32'h8000_0000, 1'b0);
        send_vertex(32'h0000_0005, 32'hFFFF_FFFB, 32'h8000_0000, 1'b1);
        set_cell_size(vsw_pkg::MD_RESET);
    endtask

    task automatic test_table_full();
        logic [31:0] first_y;
        logic [31:0] first_z;
        int          i;
        set_cell_size(31'd1);
        first_y = $urandom();
        first_z = $urandom();
        idling  = 1'b0;
        send_vertex(32'd0, first_y, first_z, 1'b0);
        for (i = 1; i < TABLE_DEPTH; i++) begin
            if (i % 128 == 0)
                idling = !idling;
            send_vertex(32'(i), $urandom(), $urandom(), 1'b0);
        end
        idling = 1'b1;
        send_vertex(32'(TABLE_DEPTH), 32'd0, 32'd0, 1'b0);
        send_vertex(32'd0, first_y, first_z, 1'b0);
        send_vertex(32'h8000_0000, 32'd0, 32'd0, 1'b1);
        send_vertex(32'd0, first_y, first_z, 1'b1);
    endtask

    task automatic test_random_objects();
        logic [31:0]               pool_x [16];
        logic [31:0]               pool_y [16];
        logic [31:0]               pool_z [16];
        logic [31:0]               x;
        logic [31:0]               y;
        logic [31:0]               z;
        logic [vsw_pkg::DIV_W-1:0] step_size;
        int                        pool_size;
        int                        obj_len;
        int                        pick;
        int                        shift;
        int                        noise_pct;
        int                        v;
        int                        objects_done;
        int                        start;
        objects_done = 0;
        start        = vertices_sent;
        while (vertices_sent - start < RANDOM_ITEMS) begin
            if (objects_done % 6 == 0) begin
                case ($urandom_range(0, 3))
                    0:       step_size = vsw_pkg::DIV_W'($urandom_range(1, 255));
                    1:       step_size = vsw_pkg::DIV_W'(1)
                                         << $urandom_range(0, vsw_pkg::DIV_W - 1);
                    2:       step_size = vsw_pkg::DIV_W'($urandom_range(256, 1 << 20));
                    default: step_size = vsw_pkg::DIV_W'($urandom());
                endcase
                set_cell_size(step_size);
            end else if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
            idling    = ($urandom_range(0, 3) != 0);
            pool_size = $urandom_range(1, 16);
            shift     = $urandom_range(0, 31);
            for (v = 0; v < pool_size; v++) begin
                pool_x[v] = $signed($urandom()) >>> shift;
                pool_y[v] = $signed($urandom()) >>> shift;
                pool_z[v] = $signed($urandom()) >>> shift;
            end
            obj_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 64);
            noise_pct = ($urandom_range(0, 2) == 0) ? 30 : 0;
            for (v = 0; v < obj_len; v++) begin
                pick = $urandom_range(0, pool_size - 1);
                x = pool_x[pick];
                y = pool_y[pick];
                z = pool_z[pick];
                // nudge across cell boundaries
                if ($urandom_range(0, 3) == 0) begin
                    x = x + 32'(int'($urandom_range(0, 6)) - 3);
                    y = y + 32'(int'($urandom_range(0, 6)) - 3);
                    z = z + 32'(int'($urandom_range(0, 6)) - 3);
                end
                if ($urandom_range(0, 99) < noise_pct) begin
                    x = $urandom();
                    y = $urandom();
                    z = $urandom();
                end
                send_vertex(x, y, z, v == obj_len - 1);
            end
            objects_done++;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        i_valid          = 1'b0;
        i_coord_x        = '0;
        i_coord_y        = '0;
        i_coord_z        = '0;
        i_last_in_object = 1'b0;
        i_stall          = 1'b0;
        idling           = 1'b0;
        stall_budget     = 0;
        cell_size        = vsw_pkg::MD_RESET;
        live_keys        = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_cell();
        test_cell_extremes();
        test_table_full();
        test_random_objects();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d vertices in %0d objects over %0d cell size settings.",
                 vertices_sent, objects, cfg_writes + 1);
        $display("Checked %0d results: %0d new keys, %0d welded, %0d on a full table.",
                 results_seen, new_keys, welded, full_hits);
        if (errors == 0)
            $display("** vertex_snap_weld: PASSED **");
        else
            $display("** vertex_snap_weld: FAILED **");
        $finish;
    end

endmodule
